// ----- rtl/core/jhfs_pkg.sv -----
// Shared types and constants for the JSON header field scanner.
// Depends on nothing; used by jhfs_classify and json_header_field_scanner_core.
package jhfs_pkg;

  localparam int unsigned KEY_COUNT = 9;
  localparam int unsigned KEY_MAX_CHARS = 16;

  // Key names are right-justified in the packed word: character i of a name
  // with length n sits in byte n-1-i.
  localparam logic [KEY_MAX_CHARS-1:0][7:0] KEY_NAMES [KEY_COUNT] = '{
    "msgId", "postDate", "topicId", "nextInTopic", "prevInTopic",
    "subject", "from", "profile", "rawEmail"
  };
  localparam logic [3:0] KEY_LENS [KEY_COUNT] = '{
    4'd5, 4'd8, 4'd7, 4'd11, 4'd11, 4'd7, 4'd4, 4'd7, 4'd8
  };

  localparam logic [3:0][7:0] WORD_TRUE  = "true";
  localparam logic [4:0][7:0] WORD_FALSE = "false";

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Word match flag bits.
  localparam int unsigned FLAG_TRUE  = 0;
  localparam int unsigned FLAG_FALSE = 1;
  localparam int unsigned FLAG_DIGIT = 2;

  typedef enum logic [1:0] {
    KIND_NULL   = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_STRING = 2'd2,
    KIND_BLOCK  = 2'd3
  } value_kind_e;

  typedef struct packed {
    logic [3:0]  key_id;
    value_kind_e value_type;
    logic [31:0] number_value;
    logic        has_string;
    logic [23:0] string_offset;
    logic [23:0] string_length;
  } result_t;

endpackage

// ----- rtl/core/jhfs_classify.sv -----
// Turns the scanner's pair state into one result beat: key id priority pick
// and reclassification of quoted values. Depends on jhfs_pkg.
module jhfs_classify #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic [jhfs_pkg::KEY_COUNT-1:0] key_match_i,
  input  jhfs_pkg::value_kind_e          kind_i,
  input  logic [31:0]                    acc_i,
  input  logic [POSITION_BITS-1:0]       start_i,
  input  logic [POSITION_BITS-1:0]       count_i,
  input  logic [2:0]                     flags_i,
  output jhfs_pkg::result_t              result_o
);

  always_comb begin
    result_o = '0;
    result_o.value_type = kind_i;
    // The lowest matching key wins.
    for (int j = jhfs_pkg::KEY_COUNT - 1; j >= 0; j--) begin
      if (key_match_i[j]) begin
        result_o.key_id = 4'(j + 1);
      end
    end
    if (kind_i == jhfs_pkg::KIND_NUMBER) begin
      result_o.number_value = acc_i;
    end
    if (kind_i == jhfs_pkg::KIND_STRING) begin
      result_o.has_string    = 1'b1;
      result_o.string_offset = 24'(start_i);
      result_o.string_length = 24'(count_i);
      if (flags_i[jhfs_pkg::FLAG_FALSE] && count_i == POSITION_BITS'(5)) begin
        result_o.value_type = jhfs_pkg::KIND_NUMBER;
      end else if (flags_i[jhfs_pkg::FLAG_TRUE] && count_i == POSITION_BITS'(4)) begin
        result_o.value_type   = jhfs_pkg::KIND_NUMBER;
        result_o.number_value = 32'd1;
      end else if (count_i == '0) begin
        result_o.value_type = jhfs_pkg::KIND_NULL;
      end else if (flags_i[jhfs_pkg::FLAG_DIGIT]) begin
        result_o.value_type   = jhfs_pkg::KIND_NUMBER;
        result_o.number_value = acc_i;
      end
    end
  end

endmodule

// ----- rtl/core/json_header_field_scanner_core.sv -----
// Top level of the JSON header field scanner: input register, scan state
// machine and result register. Depends on jhfs_pkg and jhfs_classify.
//
// The scanner takes one byte of flat JSON text per beat and sustains one
// byte per clock. A byte is scanned while it sits in the input register,
// and any result it finishes is written into the output register. A pair
// is reported when the byte after its value arrives; a bare number is
// reported when its digit run ends or when the byte flagged as last is
// scanned. Input beats stall only when both the input register and an
// untaken result are full. String offsets count bytes from the start of
// the buffer; the position counter is POSITION_BITS wide and restarts
// after every last byte.
module json_header_field_scanner_core #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            key_id_o,
  output logic [1:0]            value_type_o,
  output logic signed [31:0]    number_value_o,
  output logic                  has_string_o,
  output logic [23:0]           string_offset_o,
  output logic [23:0]           string_length_o
);

  typedef enum logic [2:0] {
    ST_KEY_WAIT   = 3'd0,
    ST_KEY        = 3'd1,
    ST_COLON      = 3'd2,
    ST_VALUE_WAIT = 3'd3,
    ST_STRING     = 3'd4,
    ST_DONE       = 3'd5
  } scan_state_e;

  typedef enum logic [1:0] {
    NUM_START = 2'd0,
    NUM_NEG   = 2'd1,
    NUM_POS   = 2'd2,
    NUM_STOP  = 2'd3
  } num_phase_e;

  typedef struct packed {
    num_phase_e  phase;
    logic [31:0] acc;
  } num_t;

  localparam logic [jhfs_pkg::KEY_COUNT-1:0] KeyAll = '1;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= jhfs_pkg::CH_ZERO && b <= jhfs_pkg::CH_NINE;
  endfunction

  // One atoi step; the accumulator wraps at 32 bits.
  function automatic num_t num_step(input num_t cur, input logic [7:0] b);
    num_t        nxt;
    logic [31:0] d;
    logic [31:0] x10;
    nxt = cur;
    d   = 32'(b[3:0]);
    x10 = (cur.acc << 3) + (cur.acc << 1);
    unique case (cur.phase)
      NUM_START: begin
        if (b == jhfs_pkg::CH_MINUS) begin
          nxt.phase = NUM_NEG;
        end else if (is_digit(b)) begin
          nxt.acc   = d;
          nxt.phase = NUM_POS;
        end else begin
          nxt.phase = NUM_STOP;
        end
      end
      NUM_NEG: begin
        if (is_digit(b)) nxt.acc = x10 - d;
        else nxt.phase = NUM_STOP;
      end
      NUM_POS: begin
        if (is_digit(b)) nxt.acc = x10 + d;
        else nxt.phase = NUM_STOP;
      end
      default: begin
      end
    endcase
    return nxt;
  endfunction

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_last_q, in_last_d;

  // Scan state.
  scan_state_e                    scan_q, scan_d, scan_u;
  logic                           skip_q, skip_d, skip_u;
  logic [POSITION_BITS-1:0]       pos_q, pos_d;
  logic [jhfs_pkg::KEY_COUNT-1:0] kmv_q, kmv_d, kmv_u;
  logic [3:0]                     klen_q, klen_d, klen_u;
  jhfs_pkg::value_kind_e          kind_q, kind_d, kind_u;
  num_t                           num_q, num_d, num_u;
  logic [POSITION_BITS-1:0]       start_q, start_d, start_u;
  logic [POSITION_BITS-1:0]       count_q, count_d, count_u;
  logic [2:0]                     flags_q, flags_d, flags_u;
  logic                           pend_q, pend_d, pend_u;

  // Result register.
  logic              out_valid_q, out_valid_d;
  jhfs_pkg::result_t out_q, out_d;
  jhfs_pkg::result_t result;

  logic       advance;
  logic       emit_u;
  logic       emit;
  logic [7:0] b;
  logic       last;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign b          = in_byte_q;
  assign last       = in_last_q;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    in_last_d  = in_last_q;
    if (advance) in_valid_d = 1'b0;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      in_byte_d  = data_byte_i;
      in_last_d  = last_byte_i;
    end
  end

  // Effect of one byte, before the end-of-buffer reset.
  always_comb begin
    scan_u  = scan_q;
    skip_u  = skip_q;
    kmv_u   = kmv_q;
    klen_u  = klen_q;
    kind_u  = kind_q;
    num_u   = num_q;
    start_u = start_q;
    count_u = count_q;
    flags_u = flags_q;
    pend_u  = pend_q;
    emit_u  = 1'b0;
    if (skip_q) begin
      skip_u = 1'b0;
      if (scan_q == ST_STRING && count_q != '1) count_u = count_q + 1'b1;
    end else if (b == jhfs_pkg::CH_BSLASH) begin
      skip_u = 1'b1;
      if (scan_q == ST_KEY) begin
        kmv_u = '0;
      end else if (scan_q == ST_STRING) begin
        if (count_q != '1) count_u = count_q + 1'b1;
        flags_u = '0;
      end else if (scan_q == ST_DONE && pend_q) begin
        num_u.phase = NUM_STOP;
      end
    end else begin
      unique case (scan_q)
        ST_KEY_WAIT: begin
          if (b == jhfs_pkg::CH_QUOTE) begin
            scan_u = ST_KEY;
            kmv_u  = KeyAll;
            klen_u = '0;
          end
        end
        ST_KEY: begin
          if (b == jhfs_pkg::CH_QUOTE) begin
            for (int j = 0; j < jhfs_pkg::KEY_COUNT; j++) begin
              if (jhfs_pkg::KEY_LENS[j] != klen_q) kmv_u[j] = 1'b0;
            end
            scan_u = ST_COLON;
          end else begin
            for (int j = 0; j < jhfs_pkg::KEY_COUNT; j++) begin
              if (klen_q >= jhfs_pkg::KEY_LENS[j] ||
                  jhfs_pkg::KEY_NAMES[j][4'(jhfs_pkg::KEY_LENS[j] - 4'd1 - klen_q)] != b) begin
                kmv_u[j] = 1'b0;
              end
            end
            if (klen_q != 4'hF) klen_u = klen_q + 4'd1;
          end
        end
        ST_COLON: begin
          if (b == jhfs_pkg::CH_COLON) scan_u = ST_VALUE_WAIT;
        end
        ST_VALUE_WAIT: begin
          if (b == jhfs_pkg::CH_QUOTE) begin
            scan_u  = ST_STRING;
            kind_u  = jhfs_pkg::KIND_STRING;
            start_u = pos_q + 1'b1;
            count_u = '0;
            flags_u = '1;
            num_u   = '{phase: NUM_START, acc: '0};
            pend_u  = 1'b0;
          end else if (b == jhfs_pkg::CH_T || b == jhfs_pkg::CH_F) begin
            scan_u = ST_DONE;
            kind_u = jhfs_pkg::KIND_NUMBER;
            num_u  = '{phase: NUM_STOP, acc: 32'(b == jhfs_pkg::CH_T)};
            pend_u = 1'b0;
          end else if (b == jhfs_pkg::CH_MINUS || is_digit(b)) begin
            scan_u = ST_DONE;
            kind_u = jhfs_pkg::KIND_NUMBER;
            num_u  = num_step('{phase: NUM_START, acc: '0}, b);
            pend_u = 1'b1;
          end else if (b == jhfs_pkg::CH_LBRACE || b == jhfs_pkg::CH_LBRACK) begin
            scan_u = ST_DONE;
            kind_u = jhfs_pkg::KIND_BLOCK;
            num_u  = '{phase: NUM_STOP, acc: '0};
            pend_u = 1'b0;
          end else if (b == jhfs_pkg::CH_RBRACE || b == jhfs_pkg::CH_RBRACK ||
                       b == jhfs_pkg::CH_COMMA) begin
            scan_u = ST_KEY_WAIT;
          end
        end
        ST_STRING: begin
          if (b == jhfs_pkg::CH_QUOTE) begin
            scan_u = ST_DONE;
          end else begin
            if (count_q >= POSITION_BITS'(4) ||
                jhfs_pkg::WORD_TRUE[2'd3 - count_q[1:0]] != b) begin
              flags_u[jhfs_pkg::FLAG_TRUE] = 1'b0;
            end
            if (count_q >= POSITION_BITS'(5) ||
                jhfs_pkg::WORD_FALSE[3'd4 - count_q[2:0]] != b) begin
              flags_u[jhfs_pkg::FLAG_FALSE] = 1'b0;
            end
            if (b != jhfs_pkg::CH_MINUS && !is_digit(b)) begin
              flags_u[jhfs_pkg::FLAG_DIGIT] = 1'b0;
            end
            num_u = num_step(num_q, b);
            if (count_q != '1) count_u = count_q + 1'b1;
          end
        end
        default: begin
          // A value has been taken; the next byte either extends a bare
          // number or closes the pair.
          if (pend_q && num_q.phase != NUM_STOP && is_digit(b)) begin
            num_u = num_step(num_q, b);
          end else begin
            emit_u = 1'b1;
            scan_u = ST_KEY_WAIT;
            pend_u = 1'b0;
          end
        end
      endcase
    end
  end

  // The classifier looks at the state after the byte, which equals the state
  // before it whenever the byte closes a pair.
  jhfs_classify #(
    .POSITION_BITS(POSITION_BITS)
  ) u_classify (
    .key_match_i(kmv_u),
    .kind_i     (kind_u),
    .acc_i      (num_u.acc),
    .start_i    (start_u),
    .count_i    (count_u),
    .flags_i    (flags_u),
    .result_o   (result)
  );

  // A bare number still running at the end of the buffer is flushed.
  assign emit = advance && (emit_u || (last && scan_u == ST_DONE && pend_u));

  always_comb begin
    scan_d  = scan_q;
    skip_d  = skip_q;
    pos_d   = pos_q;
    kmv_d   = kmv_q;
    klen_d  = klen_q;
    kind_d  = kind_q;
    num_d   = num_q;
    start_d = start_q;
    count_d = count_q;
    flags_d = flags_q;
    pend_d  = pend_q;
    if (advance) begin
      if (last) begin
        scan_d  = ST_KEY_WAIT;
        skip_d  = 1'b0;
        pos_d   = '0;
        kmv_d   = KeyAll;
        klen_d  = '0;
        kind_d  = jhfs_pkg::KIND_NULL;
        num_d   = '{phase: NUM_START, acc: '0};
        start_d = '0;
        count_d = '0;
        flags_d = '1;
        pend_d  = 1'b0;
      end else begin
        scan_d  = scan_u;
        skip_d  = skip_u;
        pos_d   = pos_q + 1'b1;
        kmv_d   = kmv_u;
        klen_d  = klen_u;
        kind_d  = kind_u;
        num_d   = num_u;
        start_d = start_u;
        count_d = count_u;
        flags_d = flags_u;
        pend_d  = pend_u;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= ST_KEY_WAIT;
      skip_q      <= 1'b0;
      pos_q       <= '0;
      kmv_q       <= KeyAll;
      klen_q      <= '0;
      kind_q      <= jhfs_pkg::KIND_NULL;
      num_q       <= '{phase: NUM_START, acc: '0};
      start_q     <= '0;
      count_q     <= '0;
      flags_q     <= '1;
      pend_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      skip_q      <= skip_d;
      pos_q       <= pos_d;
      kmv_q       <= kmv_d;
      klen_q      <= klen_d;
      kind_q      <= kind_d;
      num_q       <= num_d;
      start_q     <= start_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_last_q <= in_last_d;
    out_q     <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign key_id_o        = out_q.key_id;
  assign value_type_o    = out_q.value_type;
  assign number_value_o  = out_q.number_value;
  assign has_string_o    = out_q.has_string;
  assign string_offset_o = out_q.string_offset;
  assign string_length_o = out_q.string_length;

  // A pending bare number only exists while its value waits to be closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> scan_q == ST_DONE)
    else $error("pending number outside the value-taken state");

  // The last byte of a buffer leaves the scanner in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> scan_q == ST_KEY_WAIT && !skip_q && pos_q == '0)
    else $error("scanner not reset after the last byte");

  // Offset and length are only reported for quoted values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_string_o |-> string_offset_o == '0 && string_length_o == '0)
    else $error("string fields set on an unquoted value");

  // A result beat always names a known key id or zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_id_o <= 4'd9)
    else $error("key id out of range");

endmodule
